// File: rtl/ihss_pkg.sv
// Package for the image header size sniffer: phase codes, format codes,
// signature constants and byte helpers. No dependencies.
package ihss_pkg;

  localparam int unsigned PhaseW = 4;

  localparam logic [PhaseW-1:0] PH_COLLECT    = 4'd0;
  localparam logic [PhaseW-1:0] PH_TIFF_OFS   = 4'd1;
  localparam logic [PhaseW-1:0] PH_TIFF_SEEK  = 4'd2;
  localparam logic [PhaseW-1:0] PH_TIFF_CNT   = 4'd3;
  localparam logic [PhaseW-1:0] PH_TIFF_ENTRY = 4'd4;
  localparam logic [PhaseW-1:0] PH_JPEG_MARK  = 4'd5;
  localparam logic [PhaseW-1:0] PH_JPEG_LENHI = 4'd6;
  localparam logic [PhaseW-1:0] PH_JPEG_LENLO = 4'd7;
  localparam logic [PhaseW-1:0] PH_JPEG_SKIP  = 4'd8;
  localparam logic [PhaseW-1:0] PH_JPEG_PREC  = 4'd9;
  localparam logic [PhaseW-1:0] PH_JPEG_HHI   = 4'd10;
  localparam logic [PhaseW-1:0] PH_JPEG_HLO   = 4'd11;
  localparam logic [PhaseW-1:0] PH_JPEG_WHI   = 4'd12;
  localparam logic [PhaseW-1:0] PH_JPEG_WLO   = 4'd13;
  localparam logic [PhaseW-1:0] PH_DONE       = 4'd14;

  typedef enum logic [2:0] {
    FMT_NONE = 3'd0,
    FMT_PNG  = 3'd1,
    FMT_JPEG = 3'd2,
    FMT_WEBPL = 3'd3,
    FMT_WEBPY = 3'd4,
    FMT_GIF  = 3'd5,
    FMT_TIFF = 3'd6
  } fmt_e;

  // Number of header bytes examined for fixed-offset formats
  localparam int unsigned MinBytes = 32;

  localparam logic [15:0] TagWidth  = 16'd256;
  localparam logic [15:0] TagHeight = 16'd257;

  // Result passed from the parser to the output stage
  typedef struct packed {
    logic        found;
    fmt_e        fmt;
    logic [31:0] width;
    logic [31:0] height;
  } result_t;

  function automatic logic [15:0] rd16(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic le);
    rd16 = le ? {b1, b0} : {b0, b1};
  endfunction

  function automatic logic [31:0] rd32(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] b2, input logic [7:0] b3,
                                       input logic le);
    rd32 = le ? {b3, b2, b1, b0} : {b0, b1, b2, b3};
  endfunction

endpackage

// File: rtl/ihss_parser.sv
// Byte parser: header capture, JPEG segment walk and TIFF IFD scan.
// Depends on ihss_pkg. Produces one result request per file.
module ihss_parser import ihss_pkg::*; #(
  parameter int unsigned HeaderBytes = 32,
  parameter int unsigned PosWidth    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        byte_valid_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        res_valid_o,
  output result_t     res_o
);

  localparam int unsigned HdrIdxW = $clog2(HeaderBytes);
  localparam logic [PosWidth-1:0] PosMax = {PosWidth{1'b1}};

  logic [7:0] hdr_q [HeaderBytes];
  logic [7:0] ent_q [12];

  logic [PosWidth-1:0] pos_q, pos_d;
  logic [PhaseW-1:0]   phase_q, phase_d;
  logic [31:0]         target_q, target_d;
  logic [15:0]         seglen_q, seglen_d;
  logic [15:0]         left_q, left_d;
  logic [7:0]          acc_q, acc_d;
  logic                le_q, le_d;
  logic [31:0]         wid_q, wid_d;
  logic [31:0]         hgt_q, hgt_d;
  logic                sent_q, sent_d;
  logic [7:0]          mark_q, mark_d;
  logic [3:0]          fill_q, fill_d;
  logic                dfound_q, dfound_d;
  fmt_e                dfmt_q, dfmt_d;

  logic [7:0] b;
  logic [7:0] s [HeaderBytes];
  logic [7:0] e [12];
  logic       riff, webpl, webp, png, gif, is_sof;
  logic [15:0] len, tag, typ;
  logic [31:0] cnt, val;
  logic       enough, done;

  assign b = data_byte_i;

  // Header view including the byte arriving now
  always_comb begin
    for (int i = 0; i < HeaderBytes; i++) begin
      s[i] = (pos_q == PosWidth'(i)) ? b : hdr_q[i];
    end
    for (int i = 0; i < 11; i++) e[i] = ent_q[i];
    e[11] = b;
  end

  assign png  = s[0] == 8'h89 && s[1] == 8'h50 && s[2] == 8'h4e && s[3] == 8'h47 &&
                s[4] == 8'h0d && s[5] == 8'h0a && s[6] == 8'h1a && s[7] == 8'h0a;
  assign riff = s[0] == "R" && s[1] == "I" && s[2] == "F" && s[3] == "F";
  assign webp = s[8] == "W" && s[9] == "E" && s[10] == "B" && s[11] == "P";
  assign webpl = webp && s[12] == "V" && s[13] == "P" && s[14] == "8" && s[15] == "L";
  assign gif  = s[0] == 8'h47 && s[1] == 8'h49 && s[2] == 8'h46 && s[3] == 8'h38 &&
                (s[4] == 8'h37 || s[4] == 8'h39) && s[5] == 8'h61;
  assign len  = {acc_q, b};
  assign is_sof = mark_q[7:4] == 4'hC && mark_q != 8'hC4 && mark_q != 8'hC8 &&
                  mark_q != 8'hCC;
  assign tag = rd16(e[0], e[1], le_q);
  assign typ = rd16(e[2], e[3], le_q);
  assign cnt = rd32(e[4], e[5], e[6], e[7], le_q);

  always_comb begin
    if (typ == 16'd3)      val = {16'd0, rd16(e[8], e[9], le_q)};
    else if (typ == 16'd4) val = rd32(e[8], e[9], e[10], e[11], le_q);
    else                   val = '0;
  end

  // Phase sequencing and field capture
  always_comb begin
    pos_d = pos_q; phase_d = phase_q; target_d = target_q; seglen_d = seglen_q;
    left_d = left_q; acc_d = acc_q; le_d = le_q; wid_d = wid_q; hgt_d = hgt_q;
    sent_d = sent_q; mark_d = mark_q; fill_d = fill_q; dfound_d = dfound_q;
    dfmt_d = dfmt_q;
    res_valid_o = 1'b0;
    res_o = '0;
    enough = 1'b0;
    done = 1'b0;
    if (byte_valid_i) begin
      if (pos_q != PosMax) pos_d = pos_q + PosWidth'(1);
      case (phase_q)
        PH_COLLECT: begin
          if (pos_q == PosWidth'(1) && s[0] == 8'hFF && b == 8'hD8) begin
            phase_d = PH_JPEG_MARK;
          end else if (pos_q == PosWidth'(3) && s[0] == "I" && s[1] == "I" &&
                       s[2] == 8'd42 && b == 8'd0) begin
            le_d = 1'b1; phase_d = PH_TIFF_OFS;
          end else if (pos_q == PosWidth'(3) && s[0] == "M" && s[1] == "M" &&
                       s[2] == 8'd0 && b == 8'd42) begin
            le_d = 1'b0; phase_d = PH_TIFF_OFS;
          end else if (pos_q == PosWidth'(MinBytes - 1)) begin
            phase_d = PH_DONE;
            dfound_d = 1'b1;
            if (png) begin
              dfmt_d = FMT_PNG;
              wid_d = rd32(s[16], s[17], s[18], s[19], 1'b0);
              hgt_d = rd32(s[20], s[21], s[22], s[23], 1'b0);
            end else if (riff && webpl) begin
              dfmt_d = FMT_WEBPL;
              wid_d = {18'd0, s[22][5:0], s[21]} + 32'd1;
              hgt_d = {18'd0, s[24][3:0], s[23], s[22][7:6]} + 32'd1;
            end else if (riff && webp) begin
              dfmt_d = FMT_WEBPY;
              wid_d = {8'd0, s[26], s[25], s[24]} + 32'd1;
              hgt_d = {8'd0, s[29], s[28], s[27]} + 32'd1;
            end else if (gif) begin
              dfmt_d = FMT_GIF;
              wid_d = {16'd0, s[7], s[6]};
              hgt_d = {16'd0, s[9], s[8]};
            end else begin
              dfound_d = 1'b0; dfmt_d = FMT_NONE; wid_d = '0; hgt_d = '0;
            end
          end
        end
        PH_TIFF_OFS: begin
          if (pos_q == PosWidth'(7)) begin
            target_d = rd32(s[4], s[5], s[6], s[7], le_q);
            if (target_d < 32'd8) begin
              phase_d = PH_DONE; dfound_d = 1'b0; dfmt_d = FMT_NONE;
              wid_d = '0; hgt_d = '0;
            end else phase_d = PH_TIFF_SEEK;
          end
        end
        PH_TIFF_SEEK: begin
          if ({{(64-PosWidth){1'b0}}, pos_q} == {32'd0, target_q}) begin
            acc_d = b; phase_d = PH_TIFF_CNT;
          end
        end
        PH_TIFF_CNT: begin
          left_d = le_q ? {b, acc_q} : {acc_q, b};
          fill_d = '0;
          if (left_d == '0) begin
            phase_d = PH_DONE; dfound_d = 1'b0; dfmt_d = FMT_NONE;
            wid_d = '0; hgt_d = '0;
          end else phase_d = PH_TIFF_ENTRY;
        end
        PH_TIFF_ENTRY: begin
          if (fill_q != 4'd11) begin
            fill_d = fill_q + 4'd1;
          end else begin
            fill_d = '0;
            left_d = left_q - 16'd1;
            if (tag == TagWidth && cnt == 32'd1) begin
              wid_d = val;
              if (left_d == '0) begin
                phase_d = PH_DONE; dfound_d = 1'b0; dfmt_d = FMT_NONE;
                wid_d = '0; hgt_d = '0;
              end
            end else if (tag == TagHeight && cnt == 32'd1) begin
              phase_d = PH_DONE; dfound_d = 1'b1; dfmt_d = FMT_TIFF; hgt_d = val;
              left_d = left_q;
            end else if (tag > TagHeight) begin
              phase_d = PH_DONE; dfound_d = 1'b0; dfmt_d = FMT_NONE;
              wid_d = '0; hgt_d = '0; left_d = left_q;
            end else if (left_d == '0) begin
              phase_d = PH_DONE; dfound_d = 1'b0; dfmt_d = FMT_NONE;
              wid_d = '0; hgt_d = '0;
            end
          end
        end
        PH_JPEG_MARK: begin
          if (b != 8'hFF) begin
            mark_d = b; phase_d = PH_JPEG_LENHI;
          end
        end
        PH_JPEG_LENHI: begin
          acc_d = b; phase_d = PH_JPEG_LENLO;
        end
        PH_JPEG_LENLO: begin
          if (is_sof) phase_d = PH_JPEG_PREC;
          else if (len < 16'd2) begin
            phase_d = PH_DONE; dfound_d = 1'b0; dfmt_d = FMT_NONE;
            wid_d = '0; hgt_d = '0;
          end else if (len == 16'd2) phase_d = PH_JPEG_MARK;
          else begin
            seglen_d = len - 16'd2; phase_d = PH_JPEG_SKIP;
          end
        end
        PH_JPEG_SKIP: begin
          seglen_d = seglen_q - 16'd1;
          if (seglen_d == '0) phase_d = PH_JPEG_MARK;
        end
        PH_JPEG_PREC: phase_d = PH_JPEG_HHI;
        PH_JPEG_HHI: begin
          acc_d = b; phase_d = PH_JPEG_HLO;
        end
        PH_JPEG_HLO: begin
          hgt_d = {16'd0, acc_q, b}; phase_d = PH_JPEG_WHI;
        end
        PH_JPEG_WHI: begin
          acc_d = b; phase_d = PH_JPEG_WLO;
        end
        PH_JPEG_WLO: begin
          phase_d = PH_DONE; dfound_d = 1'b1; dfmt_d = FMT_JPEG;
          wid_d = {16'd0, acc_q, b};
        end
        default: ;
      endcase

      // Result request: at the decision once enough bytes are in, or at the end
      enough = pos_q >= PosWidth'(MinBytes - 1);
      done = phase_d == PH_DONE;
      if (!sent_q && (last_byte_i || (done && enough))) begin
        res_valid_o = 1'b1;
        sent_d = 1'b1;
        if (enough && done && dfound_d) begin
          res_o.found = 1'b1;
          res_o.fmt = dfmt_d;
          res_o.width = wid_d;
          res_o.height = hgt_d;
        end
      end

      // End of file returns all parser control state to its start; header bytes are not cleared
      if (last_byte_i) begin
        pos_d = '0; phase_d = PH_COLLECT; target_d = '0; seglen_d = '0; left_d = '0;
        acc_d = '0; le_d = 1'b0; wid_d = '0; hgt_d = '0; sent_d = 1'b0; mark_d = '0;
        fill_d = '0; dfound_d = 1'b0; dfmt_d = FMT_NONE;
      end
    end
  end

  // Header and entry byte capture
  always_ff @(posedge clk_i) begin
    if (byte_valid_i) begin
      if (pos_q < PosWidth'(HeaderBytes)) hdr_q[pos_q[HdrIdxW-1:0]] <= b;
      if (phase_q == PH_TIFF_ENTRY && fill_q < 4'd12) ent_q[fill_q] <= b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; phase_q <= PH_COLLECT; target_q <= '0; seglen_q <= '0;
      left_q <= '0; acc_q <= '0; le_q <= 1'b0; wid_q <= '0; hgt_q <= '0;
      sent_q <= 1'b0; mark_q <= '0; fill_q <= '0; dfound_q <= 1'b0;
      dfmt_q <= FMT_NONE;
    end else begin
      pos_q <= pos_d; phase_q <= phase_d; target_q <= target_d; seglen_q <= seglen_d;
      left_q <= left_d; acc_q <= acc_d; le_q <= le_d; wid_q <= wid_d; hgt_q <= hgt_d;
      sent_q <= sent_d; mark_q <= mark_d; fill_q <= fill_d; dfound_q <= dfound_d;
      dfmt_q <= dfmt_d;
    end
  end

  // Only one result request per file
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !sent_q) else $error("second result in one file");
  // A found result always carries a format
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.found) |-> res_o.fmt != FMT_NONE)
    else $error("found without format");
  // The TIFF entry fill never passes one entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < 4'd12) else $error("entry fill overflow");

endmodule

// File: rtl/image_header_size_sniffer.sv
// Each result is registered into the output buffer when its deciding byte is accepted.
// Throughput: one byte per cycle while s_axis_tready is high; the parser is never busy between bytes.
// A two-entry output buffer keeps tready high while a result waits downstream.
// Reset (rst_ni low, asynchronous) returns the parser to the start of a file
// and empties the output buffer; header bytes are not cleared.
// Depends on ihss_pkg and ihss_parser.
module image_header_size_sniffer import ihss_pkg::*; #(
  parameter int unsigned HEADER_BYTES   = 32,
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // [0] found, [3:1] format_code,
                                      // [35:4] image_width, [67:36] image_height
);

  logic    acc, res_valid;
  result_t res;
  logic [67:0] buf_q [2];
  logic [1:0]  cnt_q, cnt_d;
  logic        pop;

  // Room is guaranteed as long as at most one result is held
  assign s_axis_tready = cnt_q != 2'd2;
  assign acc = s_axis_tvalid && s_axis_tready;

  ihss_parser #(.HeaderBytes(HEADER_BYTES), .PosWidth(POSITION_WIDTH)) u_parser (
    .clk_i, .rst_ni,
    .byte_valid_i(acc), .data_byte_i(s_axis_tdata), .last_byte_i(s_axis_tlast),
    .res_valid_o(res_valid), .res_o(res)
  );

  assign m_axis_tvalid = cnt_q != 2'd0;
  assign m_axis_tdata  = {4'd0, buf_q[0]};
  assign pop = m_axis_tvalid && m_axis_tready;

  always_comb begin
    cnt_d = cnt_q + {1'b0, res_valid} - {1'b0, pop};
  end

  // Output buffer: slot 0 is the head
  always_ff @(posedge clk_i) begin
    if (res_valid && (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop))) begin
      buf_q[0] <= {res.height, res.width, res.fmt, res.found};
    end else if (pop) begin
      buf_q[0] <= buf_q[1];
    end
    if (res_valid && cnt_q == 2'd1 && !pop) begin
      buf_q[1] <= {res.height, res.width, res.fmt, res.found};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> acc) else $error("result without input byte");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cnt_q == 2'd2 && res_valid)) else $error("output buffer overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("bad buffer count");

endmodule
